FILE: rtl/tz_local_time_resolver_unit_defines.svh
// assertion macros
`ifndef TZ_LOCAL_TIME_RESOLVER_UNIT_DEFINES_SVH
`define TZ_LOCAL_TIME_RESOLVER_UNIT_DEFINES_SVH
`define TZ_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TZ_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/tzlr_pkg.sv
package tzlr_pkg;
    localparam int MaxTransitionsDefault = 256;
    localparam int TimeW = 39;
    localparam int OffW = 18;
    localparam int MinW = 12;
    localparam logic signed [TimeW-1:0] FirstValidTime = -39'sd62135596800;
    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdAppend = 2'd1;
    localparam logic [1:0] CmdUtc = 2'd2;
    localparam logic [1:0] CmdLocal = 2'd3;
    localparam logic [1:0] ErrOk = 2'd0;
    localparam logic [1:0] ErrEmpty = 2'd1;
    localparam logic [1:0] ErrFull = 2'd2;
    localparam logic [1:0] ErrBefore = 2'd3;
    localparam logic [1:0] ValUnique = 2'd0;
    localparam logic [1:0] ValAmbig = 2'd1;
    localparam logic [1:0] ValInvalid = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;      // latch input item
        logic clear;
        logic append;
        logic search_init;
        logic search_step;
        logic rd_cur;    // issue read of current entry
        logic rd_prev;
        logic rd_next;
        logic cap_cur;   // capture read data
        logic cap_prev;
        logic cap_next;
        logic compute;   // register result
        logic [1:0] err;
    } t_ctrl;

    // datapath status
    typedef struct packed {
        logic [1:0] cmd;
        logic empty;
        logic full;
        logic search_done;
        logic found;
        logic has_prev;
        logic has_next;
    } t_stat;
endpackage

FILE: rtl/tzlr_datapath.sv
module tzlr_datapath #(
    parameter int MaxTransitions = tzlr_pkg::MaxTransitionsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic [1:0] i_command,
    input  logic signed [tzlr_pkg::TimeW-1:0] i_time_seconds,
    input  logic signed [tzlr_pkg::OffW-1:0] i_offset_seconds,
    input  tzlr_pkg::t_ctrl i_ctrl,
    output tzlr_pkg::t_stat o_stat,
    output logic signed [tzlr_pkg::TimeW-1:0] o_local_seconds,
    output logic signed [tzlr_pkg::MinW-1:0] o_offset_minutes,
    output logic [7:0] o_first_index,
    output logic [7:0] o_second_index,
    output logic [1:0] o_validity,
    output logic o_well_formed,
    output logic [1:0] o_error_code
);
    localparam int AW = $clog2(MaxTransitions);
    localparam int CW = $clog2(MaxTransitions + 1);
    localparam int TW = tzlr_pkg::TimeW;
    localparam int OW = tzlr_pkg::OffW;

    logic signed [TW-1:0] r_times [MaxTransitions];
    logic signed [OW-1:0] r_offs [MaxTransitions];
    logic signed [TW-1:0] r_rd_time;
    logic signed [OW-1:0] r_rd_off;
    logic [AW-1:0] n_addr;
    logic n_rd;

    logic [CW-1:0] r_count;
    logic r_ok;
    logic signed [OW-1:0] r_prev_off;
    logic signed [TW:0] r_lbp, r_lap;
    logic [1:0] r_cmd;
    logic signed [TW-1:0] r_t;
    logic signed [OW-1:0] r_off;
    // binary search: lo..hi range over counts, r_lo = number of entries <= t
    logic [CW-1:0] r_lo, r_hi;
    logic [CW-1:0] r_mid;
    logic r_pend;
    // linear scan once the table is out of time order
    logic [CW-1:0] r_ptr;
    logic r_scan;
    logic r_sorted;
    logic signed [TW-1:0] r_last_t;
    logic [AW-1:0] r_cur;
    logic signed [TW-1:0] r_ct, r_nt;
    logic signed [OW-1:0] r_co, r_po, r_no;

    logic signed [TW:0] pre, post;
    logic [CW:0] mid_sum;
    logic [CW-1:0] mid;

    assign pre = TW'(0) + r_t + r_prev_off;
    assign post = TW'(0) + r_t + r_off;
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 1'b1;
    assign mid = mid_sum[CW:1];

    always_comb begin
        n_rd = 1'b0;
        n_addr = r_cur;
        if (i_ctrl.search_step) begin
            if (r_scan) begin
                if (r_ptr != r_count) begin
                    n_rd = 1'b1;
                    n_addr = AW'(r_ptr);
                end
            end else if (r_lo != r_hi) begin
                n_rd = 1'b1;
                n_addr = AW'(mid - 1'b1);
            end
        end else if (i_ctrl.rd_cur) begin
            n_rd = 1'b1;
            n_addr = AW'(r_lo - 1'b1);
        end else if (i_ctrl.rd_prev) begin
            n_rd = 1'b1;
            n_addr = r_cur - 1'b1;
        end else if (i_ctrl.rd_next) begin
            n_rd = 1'b1;
            n_addr = r_cur + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.append) begin
            r_times[AW'(r_count)] <= r_t;
            r_offs[AW'(r_count)] <= r_off;
        end
        if (n_rd) begin
            r_rd_time <= r_times[n_addr];
            r_rd_off <= r_offs[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ok <= 1'b0;
            r_sorted <= 1'b1;
            r_prev_off <= '0;
            r_lbp <= '0;
            r_lap <= '0;
            r_pend <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_count <= '0;
                r_ok <= 1'b0;
                r_sorted <= 1'b1;
            end
            if (i_ctrl.append) begin
                r_count <= r_count + 1'b1;
                r_prev_off <= r_off;
                if (r_count == '0) begin
                    r_ok <= (r_t == tzlr_pkg::FirstValidTime);
                    r_lbp <= post;
                    r_lap <= post;
                end else begin
                    if (r_lap >= pre || r_lbp >= pre || r_lbp >= post || r_lap >= post)
                        r_ok <= 1'b0;
                    if (r_t < r_last_t) r_sorted <= 1'b0;
                    r_lbp <= pre;
                    r_lap <= post;
                end
            end
            if (i_ctrl.search_init) r_pend <= 1'b0;
            else if (i_ctrl.search_step)
                r_pend <= r_scan ? (r_ptr != r_count) : (r_lo != r_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_t <= i_time_seconds;
            r_off <= i_offset_seconds;
        end
        if (i_ctrl.append) r_last_t <= r_t;
        if (i_ctrl.search_init) begin
            r_lo <= '0;
            r_hi <= r_count;
            r_ptr <= '0;
            r_scan <= !r_sorted;
        end else if (i_ctrl.search_step) begin
            if (r_pend) begin
                if (r_rd_time <= r_t) r_lo <= r_mid;
                else if (!r_scan) r_hi <= r_mid - 1'b1;
            end
            if (r_scan) begin
                if (r_ptr != r_count) begin
                    r_ptr <= r_ptr + 1'b1;
                    r_mid <= r_ptr + 1'b1;
                end
            end else begin
                r_mid <= mid;
            end
        end
        if (i_ctrl.rd_cur) r_cur <= AW'(r_lo - 1'b1);
        if (i_ctrl.cap_cur) begin
            r_ct <= r_rd_time;
            r_co <= r_rd_off;
        end
        if (i_ctrl.cap_prev) r_po <= r_rd_off;
        if (i_ctrl.cap_next) begin
            r_nt <= r_rd_time;
            r_no <= r_rd_off;
        end
    end

    // result computation
    localparam logic [18:0] Recip60 = 19'd279621;
    localparam int RecipShift = 24;
    logic [OW-1:0] co_abs;
    logic [OW+18:0] q_prod;
    logic [OW-1:0] q_abs;
    logic signed [OW-1:0] r_mins18;
    logic signed [TW-1:0] loc;
    logic signed [OW-1:0] pmin, pmax, nmin, nmax;
    logic signed [TW:0] plo, phi, nlo, nhi, tq;
    logic [AW-1:0] f, s;
    logic [1:0] v;

    // offset / 60 toward zero by reciprocal multiplication
    assign co_abs = r_co[OW-1] ? $unsigned(-r_co) : $unsigned(r_co);
    assign q_prod = co_abs * Recip60;
    assign q_abs = OW'(q_prod[OW+18:RecipShift]);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap_prev) r_mins18 <= r_co[OW-1] ? -$signed(q_abs) : $signed(q_abs);
    end

    assign loc = r_t + TW'(r_mins18 * 18'sd60);
    assign pmin = (r_po < r_co) ? r_po : r_co;
    assign pmax = (r_po < r_co) ? r_co : r_po;
    assign nmin = (r_co < r_no) ? r_co : r_no;
    assign nmax = (r_co < r_no) ? r_no : r_co;
    assign plo = (TW+1)'(r_ct) + pmin;
    assign phi = (TW+1)'(r_ct) + pmax;
    assign nlo = (TW+1)'(r_nt) + nmin;
    assign nhi = (TW+1)'(r_nt) + nmax;
    assign tq = (TW+1)'(r_t);

    always_comb begin
        logic done;
        done = 1'b0;
        f = r_cur;
        s = r_cur;
        v = tzlr_pkg::ValUnique;
        if (o_stat.has_prev) begin
            if (tq < plo) begin
                f = r_cur - 1'b1;
                s = r_cur - 1'b1;
                done = 1'b1;
            end else if (tq < phi) begin
                v = (r_po < r_co) ? tzlr_pkg::ValInvalid : tzlr_pkg::ValAmbig;
                f = r_cur - 1'b1;
                done = 1'b1;
            end
        end
        if (!done && o_stat.has_next) begin
            if (tq >= nhi) begin
                f = r_cur + 1'b1;
                s = r_cur + 1'b1;
            end else if (tq >= nlo) begin
                v = (r_co < r_no) ? tzlr_pkg::ValInvalid : tzlr_pkg::ValAmbig;
                s = r_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.compute) begin
            o_local_seconds <= '0;
            o_offset_minutes <= '0;
            o_first_index <= '0;
            o_second_index <= '0;
            o_validity <= tzlr_pkg::ValUnique;
            o_error_code <= i_ctrl.err;
            if (i_ctrl.err == tzlr_pkg::ErrOk && r_cmd == tzlr_pkg::CmdUtc) begin
                o_local_seconds <= loc;
                o_offset_minutes <= tzlr_pkg::MinW'(r_mins18);
                o_first_index <= 8'(r_cur);
                o_second_index <= 8'(r_cur);
            end else if (i_ctrl.err == tzlr_pkg::ErrOk && r_cmd == tzlr_pkg::CmdLocal) begin
                o_first_index <= 8'(f);
                o_second_index <= 8'(s);
                o_validity <= v;
            end
        end
    end

    assign o_well_formed = r_ok && (r_count != '0);
    assign o_stat.cmd = r_cmd;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full = (r_count >= CW'(MaxTransitions));
    assign o_stat.search_done = !r_pend && (r_scan ? (r_ptr == r_count) : (r_lo == r_hi));
    assign o_stat.found = (r_lo != '0);
    assign o_stat.has_prev = (r_cur != '0);
    assign o_stat.has_next = ((CW+1)'(r_cur) + 1'b1) < (CW+1)'(r_count);
endmodule

FILE: rtl/tzlr_controller.sv
module tzlr_controller (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  tzlr_pkg::t_stat i_stat,
    output tzlr_pkg::t_ctrl o_ctrl,
    output logic o_busy,
    output logic o_done
);
    localparam logic [3:0] SIdle = 4'd0;
    localparam logic [3:0] SDecode = 4'd1;
    localparam logic [3:0] SSearch = 4'd2;
    localparam logic [3:0] SRdCur = 4'd3;
    localparam logic [3:0] SRdPrev = 4'd4;
    localparam logic [3:0] SRdNext = 4'd5;
    localparam logic [3:0] SCapNext = 4'd6;
    localparam logic [3:0] SResult = 4'd7;
    localparam logic [3:0] SDone = 4'd8;
    localparam logic [3:0] SFirst = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_err, n_err;

    always_comb begin
        n_state = r_state;
        n_err = r_err;
        o_ctrl = '0;
        o_ctrl.err = r_err;
        case (r_state)
            SIdle: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_state = SDecode;
                end
            end
            SDecode: begin
                n_err = tzlr_pkg::ErrOk;
                o_ctrl.search_init = 1'b1;
                case (i_stat.cmd)
                    tzlr_pkg::CmdClear: begin
                        o_ctrl.clear = 1'b1;
                        n_state = SResult;
                    end
                    tzlr_pkg::CmdAppend: begin
                        if (i_stat.full) n_err = tzlr_pkg::ErrFull;
                        else o_ctrl.append = 1'b1;
                        n_state = SResult;
                    end
                    default: begin
                        if (i_stat.empty) begin
                            n_err = tzlr_pkg::ErrEmpty;
                            n_state = SResult;
                        end else begin
                            n_state = SFirst;
                        end
                    end
                endcase
            end
            SFirst: begin
                o_ctrl.search_step = 1'b1;
                n_state = SSearch;
            end
            SSearch: begin
                if (i_stat.search_done) begin
                    if (!i_stat.found) begin
                        n_err = tzlr_pkg::ErrBefore;
                        n_state = SResult;
                    end else begin
                        o_ctrl.rd_cur = 1'b1;
                        n_state = SRdCur;
                    end
                end else begin
                    o_ctrl.search_step = 1'b1;
                end
            end
            SRdCur: begin
                o_ctrl.cap_cur = 1'b1;
                o_ctrl.rd_prev = 1'b1;
                n_state = SRdPrev;
            end
            SRdPrev: begin
                o_ctrl.cap_prev = 1'b1;
                o_ctrl.rd_next = 1'b1;
                n_state = SRdNext;
            end
            SRdNext: begin
                o_ctrl.cap_next = 1'b1;
                n_state = SCapNext;
            end
            SCapNext: n_state = SResult;
            SResult: begin
                o_ctrl.compute = 1'b1;
                n_state = SDone;
            end
            SDone: n_state = SIdle;
            default: n_state = SIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SIdle;
            r_err <= tzlr_pkg::ErrOk;
        end else begin
            r_state <= n_state;
            r_err <= n_err;
        end
    end

    assign o_busy = (r_state != SIdle);
    assign o_done = (r_state == SDone);
endmodule

FILE: rtl/tz_local_time_resolver_unit.sv
// for clear, append and empty-table errors the controller steps through SDecode, SResult and SDone, where o_done rises
// queries on a time-ordered table run a binary search over the entries before reading them
// once an append goes back in time, queries scan every entry
// one item at a time: start is taken only while busy is low
// result shows one cycle on o_done; the receiver cannot stall
// synchronous active-low reset empties the table and returns to idle
module tz_local_time_resolver_unit #(
    parameter int MaxTransitions = tzlr_pkg::MaxTransitionsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  logic [1:0] i_command,
    input  logic signed [38:0] i_time_seconds,
    input  logic signed [17:0] i_offset_seconds,
    output logic o_done,
    output logic signed [38:0] o_local_seconds,
    output logic signed [11:0] o_offset_minutes,
    output logic [7:0] o_first_index,
    output logic [7:0] o_second_index,
    output logic [1:0] o_validity,
    output logic o_well_formed,
    output logic [1:0] o_error_code
);
    `include "tz_local_time_resolver_unit_defines.svh"

    tzlr_pkg::t_ctrl ctrl;
    tzlr_pkg::t_stat stat;

    tzlr_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(stat),
        .o_ctrl(ctrl), .o_busy(busy), .o_done(o_done)
    );

    tzlr_datapath #(.MaxTransitions(MaxTransitions)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_command(i_command),
        .i_time_seconds(i_time_seconds), .i_offset_seconds(i_offset_seconds),
        .i_ctrl(ctrl), .o_stat(stat), .o_local_seconds(o_local_seconds),
        .o_offset_minutes(o_offset_minutes), .o_first_index(o_first_index),
        .o_second_index(o_second_index), .o_validity(o_validity),
        .o_well_formed(o_well_formed), .o_error_code(o_error_code)
    );

    `TZ_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
    `TZ_ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, ctrl.load, !busy)
    `TZ_ASSERT_IMPL(a_err_ok_idx, i_clk, i_rst_n, o_done && o_error_code != tzlr_pkg::ErrOk,
        o_first_index == 8'd0 && o_validity == tzlr_pkg::ValUnique)
endmodule

FILE: tb/sv/tz_local_time_resolver_unit_tb.sv
module tz_local_time_resolver_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = tzlr_pkg::MaxTransitionsDefault;
    localparam longint MaxTime = 64'sd253402300799;
    localparam int WatchLimit = 2000;

    typedef struct {
        logic signed [38:0] local_s;
        logic signed [11:0] mins;
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] validity;
        logic well_formed;
        logic [1:0] err;
    } t_lookup;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_command;
    logic signed [38:0] i_time_seconds;
    logic signed [17:0] i_offset_seconds;
    logic o_done;
    logic signed [38:0] o_local_seconds;
    logic signed [11:0] o_offset_minutes;
    logic [7:0] o_first_index;
    logic [7:0] o_second_index;
    logic [1:0] o_validity;
    logic o_well_formed;
    logic [1:0] o_error_code;

    // predictor state
    longint zone_times[Depth];
    int zone_offsets[Depth];
    int zone_count;
    bit zone_ok;
    int last_offset;
    longint last_local_before;
    longint last_local_after;

    t_lookup pending_lookups[$];
    int fail_count;
    int sent_count;
    int idle_cycles;
    bit idle_on;
    int quiet_cycles;

    tz_local_time_resolver_unit u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_time_seconds(i_time_seconds),
        .i_offset_seconds(i_offset_seconds),
        .o_done(o_done),
        .o_local_seconds(o_local_seconds),
        .o_offset_minutes(o_offset_minutes),
        .o_first_index(o_first_index),
        .o_second_index(o_second_index),
        .o_validity(o_validity),
        .o_well_formed(o_well_formed),
        .o_error_code(o_error_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint last_at_or_before(longint t);
        longint found;
        found = -1;
        for (int i = 0; i < zone_count; i++) begin
            if (zone_times[i] <= t) begin
                found = longint'(i);
            end
        end
        return found;
    endfunction

    function automatic t_lookup resolve_zone(logic [1:0] cmd, longint t, int off);
        t_lookup r;
        longint cur, lo, hi, pre, post, ct, nt;
        int co, po, no, mins;
        bit done;
        r = '{default: '0};
        if (cmd == tzlr_pkg::CmdClear) begin
            zone_count = 0;
            zone_ok = 0;
        end else if (cmd == tzlr_pkg::CmdAppend) begin
            if (zone_count >= Depth) begin
                r.err = tzlr_pkg::ErrFull;
            end else begin
                if (zone_count == 0) begin
                    zone_ok = (t == tzlr_pkg::FirstValidTime);
                    last_local_before = t + off;
                    last_local_after = t + off;
                end else begin
                    pre = t + last_offset;
                    post = t + off;
                    if (last_local_after >= pre || last_local_before >= pre ||
                            last_local_before >= post || last_local_after >= post) begin
                        zone_ok = 0;
                    end
                    last_local_before = pre;
                    last_local_after = post;
                end
                last_offset = off;
                zone_times[zone_count] = t;
                zone_offsets[zone_count] = off;
                zone_count++;
            end
        end else if (zone_count == 0) begin
            r.err = tzlr_pkg::ErrEmpty;
        end else begin
            cur = last_at_or_before(t);
            if (cur < 0) begin
                r.err = tzlr_pkg::ErrBefore;
            end else if (cmd == tzlr_pkg::CmdUtc) begin
                mins = zone_offsets[cur] / 60;
                r.mins = 12'(mins);
                r.local_s = 39'(t + longint'(mins) * 60);
                r.first = 8'(cur);
                r.second = 8'(cur);
            end else begin
                ct = zone_times[cur];
                co = zone_offsets[cur];
                done = 0;
                r.first = 8'(cur);
                r.second = 8'(cur);
                if (cur > 0) begin
                    po = zone_offsets[cur - 1];
                    lo = ct + (po < co ? po : co);
                    hi = ct + (po < co ? co : po);
                    if (t < lo) begin
                        r.first = 8'(cur - 1);
                        r.second = 8'(cur - 1);
                        done = 1;
                    end else if (t < hi) begin
                        r.validity = (po < co) ? tzlr_pkg::ValInvalid : tzlr_pkg::ValAmbig;
                        r.first = 8'(cur - 1);
                        done = 1;
                    end
                end
                if (!done && cur + 1 < zone_count) begin
                    nt = zone_times[cur + 1];
                    no = zone_offsets[cur + 1];
                    lo = nt + (co < no ? co : no);
                    hi = nt + (co < no ? no : co);
                    if (t >= hi) begin
                        r.first = 8'(cur + 1);
                        r.second = 8'(cur + 1);
                    end else if (t >= lo) begin
                        r.validity = (co < no) ? tzlr_pkg::ValInvalid : tzlr_pkg::ValAmbig;
                        r.second = 8'(cur + 1);
                    end
                end
            end
        end
        r.well_formed = zone_ok && zone_count > 0;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_lookup w;
        if (i_rst_n && o_done) begin
            if (pending_lookups.size() == 0) begin
                report("unexpected transfer", 1, 0);
            end else begin
                w = pending_lookups.pop_front();
                if (o_local_seconds !== w.local_s)
                    report("local_seconds", longint'(o_local_seconds), longint'(w.local_s));
                if (o_offset_minutes !== w.mins)
                    report("offset_minutes", longint'(o_offset_minutes), longint'(w.mins));
                if (o_first_index !== w.first)
                    report("first_index", longint'(o_first_index), longint'(w.first));
                if (o_second_index !== w.second)
                    report("second_index", longint'(o_second_index), longint'(w.second));
                if (o_validity !== w.validity)
                    report("validity", longint'(o_validity), longint'(w.validity));
                if (o_well_formed !== w.well_formed)
                    report("well_formed", longint'(o_well_formed), longint'(w.well_formed));
                if (o_error_code !== w.err)
                    report("error_code", longint'(o_error_code), longint'(w.err));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WatchLimit) begin
                $display("** tz_local_time_resolver_unit: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic [1:0] cmd, longint t, int off);
        if (idle_on && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_command = cmd;
        i_time_seconds = 39'(t);
        i_offset_seconds = 18'(off);
        start = 1'b1;
        do @(posedge i_clk); while (busy);
        pending_lookups.push_back(resolve_zone(cmd, t, off));
        sent_count++;
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_lookups.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    function automatic longint rand_time();
        longint unsigned span, r;
        span = MaxTime - tzlr_pkg::FirstValidTime + 1;
        r = {$urandom, $urandom};
        return tzlr_pkg::FirstValidTime + longint'(r % span);
    endfunction

    function automatic int rand_offset();
        return int'($urandom_range(172798)) - 86399;
    endfunction

    task automatic test_empty_errors();
        send_item(tzlr_pkg::CmdUtc, 0, 0);
        send_item(tzlr_pkg::CmdLocal, MaxTime, 0);
        send_item(tzlr_pkg::CmdClear, 0, 0);
        send_item(tzlr_pkg::CmdLocal, tzlr_pkg::FirstValidTime, 0);
    endtask

    task automatic test_before_first();
        send_item(tzlr_pkg::CmdAppend, 1000, 86399);
        send_item(tzlr_pkg::CmdUtc, 999, 0);
        send_item(tzlr_pkg::CmdLocal, tzlr_pkg::FirstValidTime, 0);
        send_item(tzlr_pkg::CmdUtc, MaxTime, 0);
    endtask

    task automatic test_resolution();
        send_item(tzlr_pkg::CmdClear, 0, 0);
        send_item(tzlr_pkg::CmdAppend, tzlr_pkg::FirstValidTime, -86399);
        send_item(tzlr_pkg::CmdUtc, tzlr_pkg::FirstValidTime, 0);
        send_item(tzlr_pkg::CmdAppend, 1000, 3600);
        send_item(tzlr_pkg::CmdAppend, 100000, 0);
        send_item(tzlr_pkg::CmdAppend, 200000, -90);
        send_item(tzlr_pkg::CmdLocal, 2000, 0);
        send_item(tzlr_pkg::CmdLocal, 101000, 0);
        send_item(tzlr_pkg::CmdLocal, 999, 0);
        send_item(tzlr_pkg::CmdLocal, 5000, 0);
        send_item(tzlr_pkg::CmdUtc, 200500, 0);
        send_item(tzlr_pkg::CmdLocal, 199950, 0);
        send_item(tzlr_pkg::CmdUtc, MaxTime, 0);
        // out-of-order append makes the table ill-formed for good
        send_item(tzlr_pkg::CmdAppend, 150000, 86399);
        send_item(tzlr_pkg::CmdLocal, 160000, 0);
        send_item(tzlr_pkg::CmdAppend, MaxTime - 10, 0);
        send_item(tzlr_pkg::CmdUtc, MaxTime, 0);
        wait_drained();
    endtask

    task automatic test_full_table();
        longint t;
        send_item(tzlr_pkg::CmdClear, 0, 0);
        t = tzlr_pkg::FirstValidTime;
        for (int i = 0; i < Depth; i++) begin
            send_item(tzlr_pkg::CmdAppend, t, rand_offset());
            t += longint'($urandom_range(200000, 2000000));
        end
        send_item(tzlr_pkg::CmdAppend, t, 0);
        send_item(tzlr_pkg::CmdUtc, t, 0);
        send_item(tzlr_pkg::CmdLocal, zone_times[Depth - 1] + 10, 0);
        send_item(tzlr_pkg::CmdLocal, zone_times[128], 0);
    endtask

    task automatic test_random(int target);
        longint t;
        int n, idx, blocks;
        blocks = 0;
        while (sent_count < target) begin
            idle_on = (sent_count < target - target / 6);
            blocks++;
            if (blocks % 15 == 0) wait_drained();
            if ($urandom_range(9) < 8) begin
                send_item(tzlr_pkg::CmdClear, 0, 0);
                n = ($urandom_range(9) == 0) ? int'($urandom_range(20, 60))
                                             : int'($urandom_range(1, 10));
                t = tzlr_pkg::FirstValidTime;
                for (int i = 0; i < n; i++) begin
                    send_item(tzlr_pkg::CmdAppend, t, rand_offset());
                    t += ($urandom_range(7) == 0) ? longint'($urandom_range(0, 200000))
                                                  : longint'($urandom_range(200000, 50000000));
                end
                repeat ($urandom_range(2, 10)) begin
                    idx = int'($urandom_range(zone_count - 1));
                    t = zone_times[idx] + int'($urandom_range(180000)) - 90000;
                    if (t < tzlr_pkg::FirstValidTime) t = tzlr_pkg::FirstValidTime;
                    send_item($urandom_range(1) ? tzlr_pkg::CmdUtc : tzlr_pkg::CmdLocal, t,
                        rand_offset());
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(2'($urandom_range(3)), rand_time(), rand_offset());
                end
            end
        end
    endtask

    initial begin
        sent_count = 0;
        zone_count = 0;
        zone_ok = 0;
        last_offset = 0;
        last_local_before = 0;
        last_local_after = 0;
        idle_on = 1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = tzlr_pkg::CmdClear;
        i_time_seconds = '0;
        i_offset_seconds = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_errors();
        test_before_first();
        test_resolution();
        test_full_table();
        test_random(1250);

        while (pending_lookups.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** tz_local_time_resolver_unit: PASSED **");
        end else begin
            $display("** tz_local_time_resolver_unit: FAILED **");
        end
        $finish;
    end
endmodule
